>>> design/plup_pkg.sv
// Shared types and constants of the plane upsampler.
// Used by the controller, the datapath and the top level; depends on nothing.
package plup_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ROW_BITS    = 14;
    // The dividend is a 14-bit output index shifted up by 24 bits.
    localparam int DIV_BITS    = ROW_BITS + 24;
    localparam int DIV_CNT_W   = $clog2(DIV_BITS);
    localparam int OUT_LIMIT   = 16384;
    localparam int OUT_SIZE_W  = 15;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_H   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_W   = 3'd4;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_PRODUCE = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;
    localparam logic MODE_NEAREST = 1'b0;

    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] in_pixel;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_pixel;
        logic [ROW_BITS-1:0]           out_row;
        logic [ROW_BITS-1:0]           out_col;
        logic                          last_of_plane;
        logic                          status;
    } out_item_t;

    typedef struct packed {
        logic       load_en;
        logic       div_start;
        logic       div_step;
        logic       idx_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       mul1_en;
        logic       mul2_en;
        logic       mul3_en;
        logic       out_en;
        logic       err_en;
    } cmd_t;

    typedef struct packed {
        logic loaded;
        logic out_free;
    } stat_t;

endpackage

>>> design/plup_ctrl.sv
// Controller state machine of the plane upsampler.
// Sequences divide, index, store reads, blend and output; uses plup_pkg.
module plup_ctrl
    import plup_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_op,
    input  stat_t stat,
    output logic  s_ready,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIV  = 4'd1;
    localparam logic [3:0] ST_IDX  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_MUL1 = 4'd4;
    localparam logic [3:0] ST_MUL2 = 4'd5;
    localparam logic [3:0] ST_MUL3 = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;
    localparam logic [3:0] ST_ERR  = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_LOAD) begin
                        cmd.load_en = 1'b1;
                    end else if (!stat.loaded) begin
                        state_next = ST_ERR;
                    end else begin
                        cmd.div_start = 1'b1;
                        cnt_next      = DIV_CNT_W'(DIV_BITS - 1);
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_IDX;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_IDX: begin
                cmd.idx_en = 1'b1;
                cnt_next   = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                // Read data is registered, so each capture trails its address issue and
                // lands in the cycle after it.
                cmd.rd_sel  = cnt_reg[1:0];
                cmd.cap_en  = (cnt_reg != '0);
                cmd.cap_sel = 2'(cnt_reg - 1'b1);
                if (cnt_reg == DIV_CNT_W'(4)) begin
                    state_next = ST_MUL1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL1: begin
                cmd.mul1_en = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.err_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/plup_datapath.sv
// Datapath of the plane upsampler: configuration, counters, sample store,
// coordinate dividers, blend multipliers and output register; uses plup_pkg.
module plup_datapath
    import plup_pkg::*;
#(
    parameter int MAX_IN_HEIGHT = 64,
    parameter int MAX_IN_WIDTH  = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [SAMPLE_BITS-1:0] s_pixel,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH;
    localparam int HV = $clog2(MAX_IN_HEIGHT + 1);
    localparam int WV = $clog2(MAX_IN_WIDTH + 1);
    localparam int HB = (MAX_IN_HEIGHT > 1) ? $clog2(MAX_IN_HEIGHT) : 1;
    localparam int WB = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
    localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB = $clog2(DEPTH + 1);
    localparam int IPW = DIV_BITS - FRAC_BITS;
    localparam int PB = SAMPLE_BITS + 17;
    localparam int QB = SAMPLE_BITS + 34;
    localparam int MW = HB + WV + 1;
    localparam logic [SAMPLE_BITS-1:0] SSIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic        mode_reg;
    logic [6:0]  in_height_reg, in_width_reg;
    logic [15:0] scale_h_reg, scale_w_reg;

    logic [CB-1:0]       load_count_reg;
    logic [ROW_BITS-1:0] row_reg, col_reg;

    logic [HV-1:0] h_val, h_m1;
    logic [WV-1:0] w_val, w_m1;
    logic [15:0]   sh_eff, sw_eff;
    logic [HV+15:0] oh_prod;
    logic [WV+15:0] ow_prod;
    logic [OUT_SIZE_W-1:0] oh, ow;
    logic [HV+WV-1:0] total;
    logic [OUT_SIZE_W-1:0] row_p1, col_p1;
    logic row_end, col_end, last;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;
    logic [AB-1:0]          raddr;
    logic [HB-1:0]          rd_y;
    logic [WB-1:0]          rd_x;
    logic [MW-1:0]          addr_full;

    logic [DIV_BITS-1:0] qy_reg, qx_reg;
    logic [15:0]         remy_reg, remx_reg;
    logic [16:0]         trial_y, trial_x;
    logic [IPW-1:0]      ip_y, ip_x;

    logic [HB-1:0] y0_reg, y1_reg;
    logic [WB-1:0] x0_reg, x1_reg;
    logic [FRAC_BITS-1:0] dy_reg, dx_reg;
    logic [16:0] nx, ny;

    logic [SAMPLE_BITS-1:0] smp_reg [4];
    logic [SAMPLE_BITS-1:0] ua, ub, uc, ud;
    logic [PB-1:0] p0_reg, p1_reg, p2_reg, p3_reg, t0_reg, t1_reg;
    logic [QB-1:0] q0_reg, q1_reg, acc;
    logic [SAMPLE_BITS-1:0] pix;

    logic      m_valid_reg;
    out_item_t out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NEAREST;
            in_height_reg <= 7'd1;
            in_width_reg  <= 7'd1;
            scale_h_reg   <= 16'd256;
            scale_w_reg   <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:      mode_reg      <= cfg_wdata[0];
                REG_IN_HEIGHT: in_height_reg <= cfg_wdata[6:0];
                REG_IN_WIDTH:  in_width_reg  <= cfg_wdata[6:0];
                REG_SCALE_H:   scale_h_reg   <= cfg_wdata;
                REG_SCALE_W:   scale_w_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Effective sizes and scales.
    always_comb begin
        if (in_height_reg == 7'd0) begin
            h_val = HV'(1);
        end else if (int'(in_height_reg) > MAX_IN_HEIGHT) begin
            h_val = HV'(MAX_IN_HEIGHT);
        end else begin
            h_val = HV'(in_height_reg);
        end
        if (in_width_reg == 7'd0) begin
            w_val = WV'(1);
        end else if (int'(in_width_reg) > MAX_IN_WIDTH) begin
            w_val = WV'(MAX_IN_WIDTH);
        end else begin
            w_val = WV'(in_width_reg);
        end
    end

    assign h_m1    = h_val - 1'b1;
    assign w_m1    = w_val - 1'b1;
    assign sh_eff  = (scale_h_reg < 16'd256) ? 16'd256 : scale_h_reg;
    assign sw_eff  = (scale_w_reg < 16'd256) ? 16'd256 : scale_w_reg;
    assign oh_prod = (HV+16)'(h_val) * (HV+16)'(sh_eff);
    assign ow_prod = (WV+16)'(w_val) * (WV+16)'(sw_eff);
    assign oh = (oh_prod[HV+15:8] > OUT_LIMIT) ? OUT_SIZE_W'(OUT_LIMIT)
                                               : OUT_SIZE_W'(oh_prod[HV+15:8]);
    assign ow = (ow_prod[WV+15:8] > OUT_LIMIT) ? OUT_SIZE_W'(OUT_LIMIT)
                                               : OUT_SIZE_W'(ow_prod[WV+15:8]);
    assign total = (HV+WV)'(h_val) * (HV+WV)'(w_val);

    assign stat.loaded   = ((HV+WV+CB)'(load_count_reg) >= (HV+WV+CB)'(total));
    assign stat.out_free = !m_valid_reg || m_ready;

    // Sample store: written by loads, read once per cycle with registered data.
    always_comb begin
        unique case (cmd.rd_sel)
            2'd0: begin rd_y = y0_reg; rd_x = x0_reg; end
            2'd1: begin rd_y = y0_reg; rd_x = x1_reg; end
            2'd2: begin rd_y = y1_reg; rd_x = x0_reg; end
            2'd3: begin rd_y = y1_reg; rd_x = x1_reg; end
        endcase
    end

    assign addr_full = MW'(rd_y) * MW'(w_val) + MW'(rd_x);
    assign raddr     = AB'(addr_full);

    always_ff @(posedge aclk) begin
        if (cmd.load_en && !stat.loaded) begin
            mem[AB'(load_count_reg)] <= s_pixel;
        end
        rdata_reg <= mem[raddr];
    end

    // Restoring dividers, one quotient bit per cycle on each axis. The shift
    // register starts as the dividend and ends as the quotient.
    assign trial_y = {remy_reg, qy_reg[DIV_BITS-1]};
    assign trial_x = {remx_reg, qx_reg[DIV_BITS-1]};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            qy_reg   <= {row_reg, 24'd0};
            qx_reg   <= {col_reg, 24'd0};
            remy_reg <= '0;
            remx_reg <= '0;
        end else if (cmd.div_step) begin
            if (trial_y >= {1'b0, sh_eff}) begin
                remy_reg <= 16'(trial_y - {1'b0, sh_eff});
                qy_reg   <= {qy_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                remy_reg <= trial_y[15:0];
                qy_reg   <= {qy_reg[DIV_BITS-2:0], 1'b0};
            end
            if (trial_x >= {1'b0, sw_eff}) begin
                remx_reg <= 16'(trial_x - {1'b0, sw_eff});
                qx_reg   <= {qx_reg[DIV_BITS-2:0], 1'b1};
            end else begin
                remx_reg <= trial_x[15:0];
                qx_reg   <= {qx_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    // Clamped neighbour indices and fraction weights.
    assign ip_y = qy_reg[DIV_BITS-1:FRAC_BITS];
    assign ip_x = qx_reg[DIV_BITS-1:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (cmd.idx_en) begin
            y0_reg <= (ip_y > IPW'(h_m1)) ? HB'(h_m1) : HB'(ip_y);
            y1_reg <= (ip_y >= IPW'(h_m1)) ? HB'(h_m1) : HB'(ip_y + 1'b1);
            x0_reg <= (ip_x > IPW'(w_m1)) ? WB'(w_m1) : WB'(ip_x);
            x1_reg <= (ip_x >= IPW'(w_m1)) ? WB'(w_m1) : WB'(ip_x + 1'b1);
            dy_reg <= qy_reg[FRAC_BITS-1:0];
            dx_reg <= qx_reg[FRAC_BITS-1:0];
        end
        if (cmd.cap_en) begin
            smp_reg[cmd.cap_sel] <= rdata_reg;
        end
    end

    // Bilinear blend as two weighted passes: across columns, then rows.
    // Samples are blended in offset binary so the products stay unsigned.
    assign nx = 17'h10000 - {1'b0, dx_reg};
    assign ny = 17'h10000 - {1'b0, dy_reg};
    assign ua = smp_reg[0] ^ SSIGN;
    assign ub = smp_reg[1] ^ SSIGN;
    assign uc = smp_reg[2] ^ SSIGN;
    assign ud = smp_reg[3] ^ SSIGN;

    always_ff @(posedge aclk) begin
        if (cmd.mul1_en) begin
            p0_reg <= PB'(ua) * PB'(nx);
            p1_reg <= PB'(ub) * PB'(dx_reg);
            p2_reg <= PB'(uc) * PB'(nx);
            p3_reg <= PB'(ud) * PB'(dx_reg);
        end
        if (cmd.mul2_en) begin
            t0_reg <= p0_reg + p1_reg;
            t1_reg <= p2_reg + p3_reg;
        end
        if (cmd.mul3_en) begin
            q0_reg <= QB'(t0_reg) * QB'(ny);
            q1_reg <= QB'(t1_reg) * QB'(dy_reg);
        end
    end

    assign acc = q0_reg + q1_reg + QB'(64'h8000_0000);
    assign pix = (mode_reg == MODE_NEAREST) ? smp_reg[0]
                                            : (acc[SAMPLE_BITS+31:32] ^ SSIGN);

    // Position bookkeeping.
    assign row_p1  = {1'b0, row_reg} + 1'b1;
    assign col_p1  = {1'b0, col_reg} + 1'b1;
    assign row_end = (row_p1 >= oh);
    assign col_end = (col_p1 >= ow);
    assign last    = row_end && col_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_count_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load_en && !stat.loaded) begin
                load_count_reg <= load_count_reg + 1'b1;
            end
            if (cmd.out_en) begin
                m_valid_reg <= 1'b1;
                if (last) begin
                    row_reg        <= '0;
                    col_reg        <= '0;
                    load_count_reg <= '0;
                end else if (col_end) begin
                    col_reg <= '0;
                    row_reg <= ROW_BITS'(row_p1);
                end else begin
                    col_reg <= ROW_BITS'(col_p1);
                end
            end else if (cmd.err_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_en) begin
            out_reg.out_pixel     <= pix;
            out_reg.out_row       <= row_reg;
            out_reg.out_col       <= col_reg;
            out_reg.last_of_plane <= last;
            out_reg.status        <= STATUS_OK;
        end else if (cmd.err_en) begin
            out_reg.out_pixel     <= '0;
            out_reg.out_row       <= row_reg;
            out_reg.out_col       <= col_reg;
            out_reg.last_of_plane <= 1'b0;
            out_reg.status        <= STATUS_ERR;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> design/plane_upsample_nearest_bilinear_unit.sv
// Top level of the plane upsampler: controller plus datapath.
// Depends on plup_pkg, plup_ctrl and plup_datapath.
//
// Load items fill the sample store in raster order, and the input stays ready
// after each load; loads beyond the plane size are dropped. Each produce item
// returns the next output pixel in raster order. A produce occupies the block
// from the accepting cycle through the bit-serial coordinate dividers (one
// quotient bit per cycle for both axes at once), the clamp of the neighbour
// indices, four reads through the single store read port, the weighted
// products, their sums and the second products of the blend, and the load of
// the output register, which waits while the output register stays full.
// A produce before the plane is loaded returns status 1 with pixel zero; the
// result register loads from the error state once the output is free.
// The input side takes a new item while a finished result waits on the output.
module plane_upsample_nearest_bilinear_unit
    import plup_pkg::*;
#(
    parameter int MAX_IN_HEIGHT = 64,
    parameter int MAX_IN_WIDTH  = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cmd_t  cmd;
    stat_t stat;

    plup_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .stat    (stat),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    plup_datapath #(
        .MAX_IN_HEIGHT (MAX_IN_HEIGHT),
        .MAX_IN_WIDTH  (MAX_IN_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_pixel   (s_data.in_pixel),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
